// File: design/sst_pkg.sv
// Shared types, constants and the microcode store of the trajectory step core.
`timescale 1ns / 1ps
package sst_pkg;

  localparam int unsigned REG_W    = 64;
  localparam int unsigned ADDR_W   = 6;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned NOISE_W  = 16;
  localparam int unsigned COEF_W   = 16;
  localparam int unsigned PROD_W   = 48;
  localparam int unsigned ACC_W    = 50;
  localparam int unsigned FRAC_DROP = 13;
  localparam int unsigned UCODE_LEN = 24;
  localparam int unsigned STEP_W   = 5;

  // Register indexes, taken from paddr[5:3].
  localparam logic [2:0] REG_GAIN_FIRST   = 3'd0;
  localparam logic [2:0] REG_NOISE_FIRST  = 3'd1;
  localparam logic [2:0] REG_GAIN_STEADY  = 3'd2;
  localparam logic [2:0] REG_NOISE_STEADY = 3'd3;
  localparam logic [2:0] REG_OBSERVE      = 3'd4;
  localparam logic [2:0] REG_INIT_X       = 3'd5;
  localparam logic [2:0] REG_INIT_Y       = 3'd6;
  localparam logic [2:0] REG_START_ZERO   = 3'd7;

  typedef enum logic [3:0] {
    OP_PX, OP_VX, OP_PY, OP_VY, OP_NPX, OP_NPY, OP_NA, OP_NB, OP_NC, OP_ND
  } opnd_t;

  typedef enum logic [1:0] {MAT_GAIN, MAT_NOISE, MAT_OBS} mat_t;

  typedef enum logic [1:0] {ACC_HOLD, ACC_LOAD, ACC_ADD} acc_op_t;

  typedef enum logic [2:0] {
    WB_NONE, WB_NPX, WB_NVX, WB_NPY, WB_NVY, WB_O0, WB_O1
  } wb_t;

  typedef enum logic [1:0] {SEQ_NEXT, SEQ_WAIT_IN, SEQ_COMMIT, SEQ_RESTART} seq_op_t;

  typedef struct packed {
    opnd_t      opnd;
    mat_t       mat;
    logic [1:0] cidx;
    acc_op_t    acc;
    wb_t        wb;
    seq_op_t    seq;
  } ucode_t;

  typedef struct packed {
    ucode_t uc;
    logic   in_ready;
    logic   in_take;
    logic   commit;
  } ctl_t;

  typedef struct packed {
    logic [REG_W-1:0] gain_first;
    logic [REG_W-1:0] noise_first;
    logic [REG_W-1:0] gain_steady;
    logic [REG_W-1:0] noise_steady;
    logic [REG_W-1:0] observe_matrix;
    logic [REG_W-1:0] initial_x_pair;
    logic [REG_W-1:0] initial_y_pair;
    logic             first_pending;
    logic             load_x;
    logic             load_y;
  } cfg_view_t;

  function automatic ucode_t mk(opnd_t o, mat_t m, logic [1:0] c, acc_op_t a, wb_t w,
                                seq_op_t s);
    ucode_t u;
    u.opnd = o;
    u.mat  = m;
    u.cidx = c;
    u.acc  = a;
    u.wb   = w;
    u.seq  = s;
    return u;
  endfunction

  // One product is issued per step; the accumulator folds it in on the next step,
  // and a finished sum is rounded and written back on the step after its last product
  // has been folded in.
  function automatic ucode_t ucode_rom(logic [STEP_W-1:0] step);
    ucode_t u;
    case (step)
      5'd0:  u = mk(OP_PX,  MAT_GAIN,  2'd0, ACC_HOLD, WB_NONE, SEQ_WAIT_IN);
      5'd1:  u = mk(OP_PX,  MAT_GAIN,  2'd0, ACC_HOLD, WB_NONE, SEQ_NEXT);
      5'd2:  u = mk(OP_VX,  MAT_GAIN,  2'd2, ACC_LOAD, WB_NONE, SEQ_NEXT);
      5'd3:  u = mk(OP_NA,  MAT_NOISE, 2'd0, ACC_ADD,  WB_NONE, SEQ_NEXT);
      5'd4:  u = mk(OP_NB,  MAT_NOISE, 2'd2, ACC_ADD,  WB_NONE, SEQ_NEXT);
      5'd5:  u = mk(OP_PX,  MAT_GAIN,  2'd1, ACC_ADD,  WB_NONE, SEQ_NEXT);
      5'd6:  u = mk(OP_VX,  MAT_GAIN,  2'd3, ACC_LOAD, WB_NPX,  SEQ_NEXT);
      5'd7:  u = mk(OP_NA,  MAT_NOISE, 2'd1, ACC_ADD,  WB_NONE, SEQ_NEXT);
      5'd8:  u = mk(OP_NB,  MAT_NOISE, 2'd3, ACC_ADD,  WB_NONE, SEQ_NEXT);
      5'd9:  u = mk(OP_PY,  MAT_GAIN,  2'd0, ACC_ADD,  WB_NONE, SEQ_NEXT);
      5'd10: u = mk(OP_VY,  MAT_GAIN,  2'd2, ACC_LOAD, WB_NVX,  SEQ_NEXT);
      5'd11: u = mk(OP_NC,  MAT_NOISE, 2'd0, ACC_ADD,  WB_NONE, SEQ_NEXT);
      5'd12: u = mk(OP_ND,  MAT_NOISE, 2'd2, ACC_ADD,  WB_NONE, SEQ_NEXT);
      5'd13: u = mk(OP_PY,  MAT_GAIN,  2'd1, ACC_ADD,  WB_NONE, SEQ_NEXT);
      5'd14: u = mk(OP_VY,  MAT_GAIN,  2'd3, ACC_LOAD, WB_NPY,  SEQ_NEXT);
      5'd15: u = mk(OP_NC,  MAT_NOISE, 2'd1, ACC_ADD,  WB_NONE, SEQ_NEXT);
      5'd16: u = mk(OP_ND,  MAT_NOISE, 2'd3, ACC_ADD,  WB_NONE, SEQ_NEXT);
      5'd17: u = mk(OP_NPX, MAT_OBS,   2'd0, ACC_ADD,  WB_NONE, SEQ_NEXT);
      5'd18: u = mk(OP_NPY, MAT_OBS,   2'd1, ACC_LOAD, WB_NVY,  SEQ_NEXT);
      5'd19: u = mk(OP_NPX, MAT_OBS,   2'd2, ACC_ADD,  WB_NONE, SEQ_NEXT);
      5'd20: u = mk(OP_NPY, MAT_OBS,   2'd3, ACC_LOAD, WB_O0,   SEQ_NEXT);
      5'd21: u = mk(OP_PX,  MAT_GAIN,  2'd0, ACC_ADD,  WB_NONE, SEQ_NEXT);
      5'd22: u = mk(OP_PX,  MAT_GAIN,  2'd0, ACC_HOLD, WB_O1,   SEQ_NEXT);
      5'd23: u = mk(OP_PX,  MAT_GAIN,  2'd0, ACC_HOLD, WB_NONE, SEQ_COMMIT);
      default: u = mk(OP_PX, MAT_GAIN, 2'd0, ACC_HOLD, WB_NONE, SEQ_RESTART);
    endcase
    return u;
  endfunction

endpackage

// File: design/sst_in_if.sv
// Input channel: four noise samples per transaction.
`timescale 1ns / 1ps
interface sst_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] noise_a;
  logic signed [15:0] noise_b;
  logic signed [15:0] noise_c;
  logic signed [15:0] noise_d;

  modport source (output valid, output noise_a, output noise_b, output noise_c,
                  output noise_d, input ready);
  modport sink   (input valid, input noise_a, input noise_b, input noise_c,
                  input noise_d, output ready);
endinterface

// File: design/sst_out_if.sv
// Result channel: observed coordinates and velocities per transaction.
`timescale 1ns / 1ps
interface sst_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] observed_first;
  logic signed [31:0] observed_second;
  logic signed [31:0] velocity_x;
  logic signed [31:0] velocity_y;

  modport source (output valid, output observed_first, output observed_second,
                  output velocity_x, output velocity_y, input ready);
  modport sink   (input valid, input observed_first, input observed_second,
                  input velocity_x, input velocity_y, output ready);
endinterface

// File: design/sst_regs.sv
// Configuration register file behind the APB-style port.
`timescale 1ns / 1ps
module sst_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [sst_pkg::ADDR_W-1:0]       paddr,
  input  logic [sst_pkg::REG_W-1:0]        pwdata,
  output logic [sst_pkg::REG_W-1:0]        prdata,
  input  logic                             step_done,
  output sst_pkg::cfg_view_t               cfg
);

  logic [sst_pkg::REG_W-1:0] gain_first_r, noise_first_r, gain_steady_r, noise_steady_r;
  logic [sst_pkg::REG_W-1:0] observe_r, init_x_r, init_y_r;
  logic                      start_zero_r, first_pending_r, first_pending_nxt;
  logic                      wr;
  logic [2:0]                idx;

  assign wr  = psel && penable && pwrite;
  assign idx = paddr[5:3];

  always_comb begin
    first_pending_nxt = first_pending_r;
    if (step_done) begin
      first_pending_nxt = 1'b0;
    end
    if (wr) begin
      case (idx)
        sst_pkg::REG_INIT_X:     first_pending_nxt = start_zero_r;
        sst_pkg::REG_INIT_Y:     first_pending_nxt = start_zero_r;
        sst_pkg::REG_START_ZERO: first_pending_nxt = pwdata[0];
        default:                 first_pending_nxt = first_pending_nxt;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_first_r    <= '0;
      noise_first_r   <= '0;
      gain_steady_r   <= '0;
      noise_steady_r  <= '0;
      observe_r       <= '0;
      init_x_r        <= '0;
      init_y_r        <= '0;
      start_zero_r    <= 1'b1;
      first_pending_r <= 1'b1;
    end else begin
      first_pending_r <= first_pending_nxt;
      if (wr) begin
        case (idx)
          sst_pkg::REG_GAIN_FIRST:   gain_first_r   <= pwdata;
          sst_pkg::REG_NOISE_FIRST:  noise_first_r  <= pwdata;
          sst_pkg::REG_GAIN_STEADY:  gain_steady_r  <= pwdata;
          sst_pkg::REG_NOISE_STEADY: noise_steady_r <= pwdata;
          sst_pkg::REG_OBSERVE:      observe_r      <= pwdata;
          sst_pkg::REG_INIT_X:       init_x_r       <= pwdata;
          sst_pkg::REG_INIT_Y:       init_y_r       <= pwdata;
          sst_pkg::REG_START_ZERO:   start_zero_r   <= pwdata[0];
          default:                   start_zero_r   <= start_zero_r;
        endcase
      end
    end
  end

  always_comb begin
    case (idx)
      sst_pkg::REG_GAIN_FIRST:   prdata = gain_first_r;
      sst_pkg::REG_NOISE_FIRST:  prdata = noise_first_r;
      sst_pkg::REG_GAIN_STEADY:  prdata = gain_steady_r;
      sst_pkg::REG_NOISE_STEADY: prdata = noise_steady_r;
      sst_pkg::REG_OBSERVE:      prdata = observe_r;
      sst_pkg::REG_INIT_X:       prdata = init_x_r;
      sst_pkg::REG_INIT_Y:       prdata = init_y_r;
      sst_pkg::REG_START_ZERO:   prdata = {{(sst_pkg::REG_W-1){1'b0}}, start_zero_r};
      default:                   prdata = '0;
    endcase
  end

  // The state loads straight from the write data, in the same edge as the register.
  always_comb begin
    cfg.gain_first     = gain_first_r;
    cfg.noise_first    = noise_first_r;
    cfg.gain_steady    = gain_steady_r;
    cfg.noise_steady   = noise_steady_r;
    cfg.observe_matrix = observe_r;
    cfg.initial_x_pair = pwdata;
    cfg.initial_y_pair = pwdata;
    cfg.first_pending  = first_pending_r;
    cfg.load_x         = wr && (idx == sst_pkg::REG_INIT_X);
    cfg.load_y         = wr && (idx == sst_pkg::REG_INIT_Y);
  end

endmodule

// File: design/sst_seq.sv
// Microcode sequencer: step counter, control store and jump conditions.
`timescale 1ns / 1ps
module sst_seq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          out_free,
  output sst_pkg::ctl_t ctl
);

  logic [sst_pkg::STEP_W-1:0] step_r, step_nxt;
  sst_pkg::ucode_t            uc;

  assign uc = sst_pkg::ucode_rom(step_r);

  always_comb begin
    ctl.uc       = uc;
    ctl.in_ready = (uc.seq == sst_pkg::SEQ_WAIT_IN);
    ctl.in_take  = ctl.in_ready && in_valid;
    ctl.commit   = (uc.seq == sst_pkg::SEQ_COMMIT) && out_free;
    case (uc.seq)
      sst_pkg::SEQ_NEXT:    step_nxt = step_r + 1'b1;
      sst_pkg::SEQ_WAIT_IN: step_nxt = in_valid ? step_r + 1'b1 : step_r;
      sst_pkg::SEQ_COMMIT:  step_nxt = out_free ? '0 : step_r;
      sst_pkg::SEQ_RESTART: step_nxt = '0;
      default:              step_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

// File: design/sst_dp.sv
// Datapath: operand selection, shared multiply-accumulate, rounding and state.
`timescale 1ns / 1ps
module sst_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  sst_pkg::cfg_view_t  cfg,
  input  sst_pkg::ctl_t       ctl,
  input  logic signed [15:0]  noise_a,
  input  logic signed [15:0]  noise_b,
  input  logic signed [15:0]  noise_c,
  input  logic signed [15:0]  noise_d,
  output logic signed [31:0]  observed_first,
  output logic signed [31:0]  observed_second,
  output logic signed [31:0]  velocity_x,
  output logic signed [31:0]  velocity_y
);

  localparam int unsigned W  = sst_pkg::WORD_W;
  localparam int unsigned AW = sst_pkg::ACC_W;
  localparam int unsigned QW = AW + 1 - sst_pkg::FRAC_DROP;

  logic signed [W-1:0]  pos_x_r, vel_x_r, pos_y_r, vel_y_r;
  logic signed [W-1:0]  npx_r, nvx_r, npy_r, nvy_r, o0_r, o1_r;
  logic signed [15:0]   na_r, nb_r, nc_r, nd_r;
  logic signed [sst_pkg::PROD_W-1:0] prod_r;
  logic signed [AW-1:0] acc_r;
  logic [sst_pkg::REG_W-1:0] mat_word;
  logic signed [sst_pkg::COEF_W-1:0] coef;
  logic signed [W-1:0]  opnd;
  logic signed [AW:0]   biased;
  logic signed [QW-1:0] quot;
  logic signed [W-1:0]  rnd;

  function automatic logic signed [31:0] noise_op(logic signed [15:0] n);
    // Noise is Q3.12 against Q16.16 state, so it enters sixteen times larger.
    return {{12{n[15]}}, n, 4'b0000};
  endfunction

  always_comb begin
    case (ctl.uc.mat)
      sst_pkg::MAT_GAIN:  mat_word = cfg.first_pending ? cfg.gain_first : cfg.gain_steady;
      sst_pkg::MAT_NOISE: mat_word = cfg.first_pending ? cfg.noise_first : cfg.noise_steady;
      sst_pkg::MAT_OBS:   mat_word = cfg.observe_matrix;
      default:            mat_word = '0;
    endcase
    coef = mat_word[{ctl.uc.cidx, 4'b0000} +: sst_pkg::COEF_W];

    case (ctl.uc.opnd)
      sst_pkg::OP_PX:  opnd = pos_x_r;
      sst_pkg::OP_VX:  opnd = vel_x_r;
      sst_pkg::OP_PY:  opnd = pos_y_r;
      sst_pkg::OP_VY:  opnd = vel_y_r;
      sst_pkg::OP_NPX: opnd = npx_r;
      sst_pkg::OP_NPY: opnd = npy_r;
      sst_pkg::OP_NA:  opnd = noise_op(na_r);
      sst_pkg::OP_NB:  opnd = noise_op(nb_r);
      sst_pkg::OP_NC:  opnd = noise_op(nc_r);
      sst_pkg::OP_ND:  opnd = noise_op(nd_r);
      default:         opnd = '0;
    endcase
  end

  // Round half up from 29 to 16 fraction bits, then clamp to the 32-bit range.
  always_comb begin
    biased = (AW + 1)'(acc_r) + (AW + 1)'(1 << (sst_pkg::FRAC_DROP - 1));
    quot   = biased[AW:sst_pkg::FRAC_DROP];
    if (quot[QW-1:W-1] == {(QW - W + 1){quot[QW-1]}}) begin
      rnd = quot[W-1:0];
    end else begin
      rnd = quot[QW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= sst_pkg::PROD_W'(coef) * sst_pkg::PROD_W'(opnd);
    case (ctl.uc.acc)
      sst_pkg::ACC_LOAD: acc_r <= AW'(prod_r);
      sst_pkg::ACC_ADD:  acc_r <= acc_r + AW'(prod_r);
      default:           acc_r <= acc_r;
    endcase
    case (ctl.uc.wb)
      sst_pkg::WB_NPX: npx_r <= rnd;
      sst_pkg::WB_NVX: nvx_r <= rnd;
      sst_pkg::WB_NPY: npy_r <= rnd;
      sst_pkg::WB_NVY: nvy_r <= rnd;
      sst_pkg::WB_O0:  o0_r  <= rnd;
      sst_pkg::WB_O1:  o1_r  <= rnd;
      default:         o1_r  <= o1_r;
    endcase
    if (ctl.in_take) begin
      na_r <= noise_a;
      nb_r <= noise_b;
      nc_r <= noise_c;
      nd_r <= noise_d;
    end
    if (ctl.commit) begin
      observed_first  <= o0_r;
      observed_second <= o1_r;
      velocity_x      <= nvx_r;
      velocity_y      <= nvy_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r <= '0;
      vel_x_r <= '0;
      pos_y_r <= '0;
      vel_y_r <= '0;
    end else begin
      if (cfg.load_x) begin
        pos_x_r <= cfg.initial_x_pair[31:0];
        vel_x_r <= cfg.initial_x_pair[63:32];
      end else if (ctl.commit) begin
        pos_x_r <= npx_r;
        vel_x_r <= nvx_r;
      end
      if (cfg.load_y) begin
        pos_y_r <= cfg.initial_y_pair[31:0];
        vel_y_r <= cfg.initial_y_pair[63:32];
      end else if (ctl.commit) begin
        pos_y_r <= npy_r;
        vel_y_r <= nvy_r;
      end
    end
  end

endmodule

// File: design/state_space_trajectory_step_core.sv
// An accepted input transaction runs through the whole microcode program before its result appears on out_ch.
// Input is taken only in the idle step, so a new transaction waits until the last one has gone through the 20 products
// of the single shared multiply-accumulate and the commit step of the microcode program.
// A result waiting on out_ch stalls the commit step until it is taken.
// Reset (rst_n low, synchronous): configuration registers and state go to zero, start_at_zero to one.
`timescale 1ns / 1ps
module state_space_trajectory_step_core (
  input  logic                         clk,
  input  logic                         rst_n,
  sst_in_if.sink                       in_ch,
  sst_out_if.source                    out_ch,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [sst_pkg::ADDR_W-1:0]   paddr,
  input  logic [sst_pkg::REG_W-1:0]    pwdata,
  output logic [sst_pkg::REG_W-1:0]    prdata,
  output logic                         pready
);

  sst_pkg::cfg_view_t cfg;
  sst_pkg::ctl_t      ctl;
  logic               out_valid_r, out_valid_nxt;
  logic               out_free;

  assign pready      = 1'b1;
  assign out_free    = !out_valid_r || out_ch.ready;
  assign in_ch.ready = ctl.in_ready;
  assign out_ch.valid = out_valid_r;

  sst_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .step_done (ctl.commit),
    .cfg       (cfg)
  );

  sst_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .out_free (out_free),
    .ctl      (ctl)
  );

  sst_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg),
    .ctl             (ctl),
    .noise_a         (in_ch.noise_a),
    .noise_b         (in_ch.noise_b),
    .noise_c         (in_ch.noise_c),
    .noise_d         (in_ch.noise_d),
    .observed_first  (out_ch.observed_first),
    .observed_second (out_ch.observed_second),
    .velocity_x      (out_ch.velocity_x),
    .velocity_y      (out_ch.velocity_y)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (ctl.commit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("input accepted again while a transaction is in progress");

  a_result_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(ctl.commit))
    else $error("result raised without a commit step");

  a_idle_after_commit: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.commit |=> in_ch.ready)
    else $error("sequencer did not return to idle after commit");
`endif

endmodule
